// ===== rtl/qmm_pkg.sv =====
// ----------------------------------------------------------------------------
// qmm_pkg : shared types and constants for the quad motor mixer
// Field widths, configuration register indexes, stage words and helpers.
// ----------------------------------------------------------------------------
package qmm_pkg;

  // field widths
  localparam int unsigned ANG_W  = 16;
  localparam int unsigned STK_W  = 8;
  localparam int unsigned OFF_W  = STK_W + 1;   // signed stick offset
  localparam int unsigned DIF_W  = ANG_W + 1;   // signed prev - cur
  localparam int unsigned KQ_W   = 7;           // floor(1023 / 10) = 102
  localparam int unsigned GAIN_W = 8;
  localparam int unsigned PWM_W  = 12;
  localparam int unsigned CFG_W  = 10;
  localparam int unsigned IDX_W  = 3;
  // product and sum widths, with headroom for the worst case
  localparam int unsigned P_W    = 25;
  localparam int unsigned S_W    = 27;

  localparam logic [STK_W-1:0] STICK_MID = STK_W'(128);

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_KP_ANGLE      = 3'd0,
    REG_KD_ANGLE      = 3'd1,
    REG_KP_RATE       = 3'd2,
    REG_KD_RATE       = 3'd3,
    REG_THROTTLE_GAIN = 3'd4,
    REG_HANDLE_GAIN   = 3'd5,
    REG_ROTATE_GAIN   = 3'd6,
    REG_POSTURE_GAIN  = 3'd7
  } cfg_idx_e;

  // stage 1: captured sample, derivative differences, stick offsets
  typedef struct packed {
    logic signed [ANG_W-1:0] ax;
    logic signed [ANG_W-1:0] ay;
    logic signed [ANG_W-1:0] gx;
    logic signed [ANG_W-1:0] gy;
    logic signed [ANG_W-1:0] gz;
    logic signed [DIF_W-1:0] dax;
    logic signed [DIF_W-1:0] day;
    logic signed [DIF_W-1:0] dgx;
    logic signed [DIF_W-1:0] dgy;
    logic signed [OFF_W-1:0] yaw_off;
    logic signed [OFF_W-1:0] pitch_off;
    logic signed [OFF_W-1:0] roll_off;
    logic signed [OFF_W-1:0] thr_off;
    logic                    yaw_mid;
  } s1_t;

  // stage 2: products
  typedef struct packed {
    logic signed [P_W-1:0] ax_p;
    logic signed [P_W-1:0] axd_p;
    logic signed [P_W-1:0] ay_p;
    logic signed [P_W-1:0] ayd_p;
    logic signed [P_W-1:0] gx_p;
    logic signed [P_W-1:0] gxd_p;
    logic signed [P_W-1:0] gy_p;
    logic signed [P_W-1:0] gyd_p;
    logic signed [P_W-1:0] thr_p;
    logic signed [P_W-1:0] roll_p;
    logic signed [P_W-1:0] pitch_p;
    logic signed [P_W-1:0] yaw_p;
    logic signed [P_W-1:0] gz_p;
    logic                  yaw_mid;
  } s2_t;

  // stage 3: PD terms and stick/yaw partial sums per motor
  typedef struct packed {
    logic signed [S_W-1:0] pax;
    logic signed [S_W-1:0] pay;
    logic signed [S_W-1:0] pgx;
    logic signed [S_W-1:0] pgy;
    logic signed [S_W-1:0] left_c;
    logic signed [S_W-1:0] right_c;
    logic signed [S_W-1:0] front_c;
    logic signed [S_W-1:0] back_c;
  } s3_t;

  // floor(v / 10) for v below 1029, by reciprocal 205 / 2048
  function automatic logic [KQ_W-1:0] div10(input logic [CFG_W-1:0] v);
    logic [17:0] p;
    p = 18'(v) * 18'd205;
    return p[17:11];
  endfunction

  // limit to hi first, then raise to lo
  function automatic logic [PWM_W-1:0] pwm_clamp(input logic signed [S_W-1:0] v,
                                                 input logic signed [S_W-1:0] lo,
                                                 input logic signed [S_W-1:0] hi);
    logic signed [S_W-1:0] r;
    r = v;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r[PWM_W-1:0];
  endfunction

endpackage

// ===== rtl/quad_motor_mixer_pd_core.sv =====
// ----------------------------------------------------------------------------
// quad_motor_mixer_pd_core : plus-frame quad mixer with PD stabilisation
// Angle and gyro PD terms, stick mixing, yaw hold and PWM clamping.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                | payload
//  ----------+-----------+--------------------------+-------------------------
//  sample in | input     | in_valid_i / in_ready_o  | angles, rates, sticks
//  pwm out   | output    | out_valid_o / out_ready_i| four 12-bit motor words
//  config    | input     | cfg_we_i (no wait)       | cfg_idx_i, cfg_wdata_i
//
// One word per cycle sustained while out_ready_i stays high; four register
// stages (capture, multiply, PD sum, mix and clamp), the last driving the outputs.
// Each stage holds under back-pressure only when it is full and the next
// stage cannot take its word, so bubbles close up and input keeps flowing.
// Reset clears the stage valid bits, the previous-sample registers and the
// gain registers (PD gains 0, stick and yaw gains 1).
// ----------------------------------------------------------------------------
module quad_motor_mixer_pd_core
  import qmm_pkg::*;
#(
  parameter int unsigned BASE_LEFT  = 2048,
  parameter int unsigned BASE_RIGHT = 2048,
  parameter int unsigned BASE_FRONT = 2048,
  parameter int unsigned BASE_BACK  = 2048,
  parameter int unsigned PWM_LO     = 0,
  parameter int unsigned PWM_HI     = 4095
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration
  input  logic                    cfg_we_i,
  input  logic [IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_wdata_i,
  // sample in
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [ANG_W-1:0] angle_x_i,
  input  logic signed [ANG_W-1:0] angle_y_i,
  input  logic signed [ANG_W-1:0] rate_x_i,
  input  logic signed [ANG_W-1:0] rate_y_i,
  input  logic signed [ANG_W-1:0] rate_z_i,
  input  logic [STK_W-1:0]        yaw_stick_i,
  input  logic [STK_W-1:0]        pitch_stick_i,
  input  logic [STK_W-1:0]        roll_stick_i,
  input  logic [STK_W-1:0]        throttle_stick_i,
  // pwm out
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [PWM_W-1:0]        pwm_left_o,
  output logic [PWM_W-1:0]        pwm_right_o,
  output logic [PWM_W-1:0]        pwm_front_o,
  output logic [PWM_W-1:0]        pwm_back_o
);

  localparam logic signed [S_W-1:0] BASE_L_S = S_W'(BASE_LEFT);
  localparam logic signed [S_W-1:0] BASE_R_S = S_W'(BASE_RIGHT);
  localparam logic signed [S_W-1:0] BASE_F_S = S_W'(BASE_FRONT);
  localparam logic signed [S_W-1:0] BASE_B_S = S_W'(BASE_BACK);
  localparam logic signed [S_W-1:0] LO_S     = S_W'(PWM_LO);
  localparam logic signed [S_W-1:0] HI_S     = S_W'(PWM_HI);

  // gain registers; PD gains are held already divided by ten
  logic [KQ_W-1:0]   kp_ang_q, kd_ang_q, kp_rate_q, kd_rate_q;
  logic [GAIN_W-1:0] thr_gain_q, hnd_gain_q, rot_gain_q, pst_gain_q;

  // previous-sample registers
  logic signed [ANG_W-1:0] prev_ax_q, prev_ay_q, prev_gx_q, prev_gy_q;

  // pipeline
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic in_fire;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  logic [PWM_W-1:0] left_d, right_d, front_d, back_d;
  logic [PWM_W-1:0] left_q, right_q, front_q, back_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_ang_q   <= '0;
      kd_ang_q   <= '0;
      kp_rate_q  <= '0;
      kd_rate_q  <= '0;
      thr_gain_q <= GAIN_W'(1);
      hnd_gain_q <= GAIN_W'(1);
      rot_gain_q <= GAIN_W'(1);
      pst_gain_q <= GAIN_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_KP_ANGLE:      kp_ang_q   <= div10(cfg_wdata_i);
        REG_KD_ANGLE:      kd_ang_q   <= div10(cfg_wdata_i);
        REG_KP_RATE:       kp_rate_q  <= div10(cfg_wdata_i);
        REG_KD_RATE:       kd_rate_q  <= div10(cfg_wdata_i);
        REG_THROTTLE_GAIN: thr_gain_q <= cfg_wdata_i[GAIN_W-1:0];
        REG_HANDLE_GAIN:   hnd_gain_q <= cfg_wdata_i[GAIN_W-1:0];
        REG_ROTATE_GAIN:   rot_gain_q <= cfg_wdata_i[GAIN_W-1:0];
        REG_POSTURE_GAIN:  pst_gain_q <= cfg_wdata_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // per-stage flow control
  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;
  assign in_fire    = in_valid_i && rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // previous samples move on with each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_ax_q <= '0;
      prev_ay_q <= '0;
      prev_gx_q <= '0;
      prev_gy_q <= '0;
    end else if (in_fire) begin
      prev_ax_q <= angle_x_i;
      prev_ay_q <= angle_y_i;
      prev_gx_q <= rate_x_i;
      prev_gy_q <= rate_y_i;
    end
  end

  // stage 1: capture, differences, stick offsets
  always_comb begin
    s1_d.ax        = angle_x_i;
    s1_d.ay        = angle_y_i;
    s1_d.gx        = rate_x_i;
    s1_d.gy        = rate_y_i;
    s1_d.gz        = rate_z_i;
    s1_d.dax       = DIF_W'(prev_ax_q) - DIF_W'(angle_x_i);
    s1_d.day       = DIF_W'(prev_ay_q) - DIF_W'(angle_y_i);
    s1_d.dgx       = DIF_W'(prev_gx_q) - DIF_W'(rate_x_i);
    s1_d.dgy       = DIF_W'(prev_gy_q) - DIF_W'(rate_y_i);
    s1_d.yaw_off   = $signed({1'b0, yaw_stick_i}) - $signed({1'b0, STICK_MID});
    s1_d.pitch_off = $signed({1'b0, pitch_stick_i}) - $signed({1'b0, STICK_MID});
    s1_d.roll_off  = $signed({1'b0, roll_stick_i}) - $signed({1'b0, STICK_MID});
    s1_d.thr_off   = $signed({1'b0, throttle_stick_i}) - $signed({1'b0, STICK_MID});
    s1_d.yaw_mid   = (yaw_stick_i == STICK_MID);
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) s1_q <= s1_d;
  end

  // stage 2: independent products, operands widened to the product width
  always_comb begin
    logic signed [P_W-1:0] kpa, kda, kpr, kdr, gth, ghd, grt, gps;
    kpa = P_W'($signed({1'b0, kp_ang_q}));
    kda = P_W'($signed({1'b0, kd_ang_q}));
    kpr = P_W'($signed({1'b0, kp_rate_q}));
    kdr = P_W'($signed({1'b0, kd_rate_q}));
    gth = P_W'($signed({1'b0, thr_gain_q}));
    ghd = P_W'($signed({1'b0, hnd_gain_q}));
    grt = P_W'($signed({1'b0, rot_gain_q}));
    gps = P_W'($signed({1'b0, pst_gain_q}));
    s2_d.ax_p    = P_W'($signed(s1_q.ax)) * kpa;
    s2_d.axd_p   = P_W'($signed(s1_q.dax)) * kda;
    s2_d.ay_p    = P_W'($signed(s1_q.ay)) * kpa;
    s2_d.ayd_p   = P_W'($signed(s1_q.day)) * kda;
    s2_d.gx_p    = P_W'($signed(s1_q.gx)) * kpr;
    s2_d.gxd_p   = P_W'($signed(s1_q.dgx)) * kdr;
    s2_d.gy_p    = P_W'($signed(s1_q.gy)) * kpr;
    s2_d.gyd_p   = P_W'($signed(s1_q.dgy)) * kdr;
    s2_d.thr_p   = P_W'($signed(s1_q.thr_off)) * gth;
    s2_d.roll_p  = P_W'($signed(s1_q.roll_off)) * ghd;
    s2_d.pitch_p = P_W'($signed(s1_q.pitch_off)) * ghd;
    s2_d.yaw_p   = P_W'($signed(s1_q.yaw_off)) * grt;
    s2_d.gz_p    = P_W'($signed(s1_q.gz)) * gps;
    s2_d.yaw_mid = s1_q.yaw_mid;
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) s2_q <= s2_d;
  end

  // stage 3: PD terms, yaw selection and stick partial sums
  always_comb begin
    logic signed [S_W-1:0] zl, zf, thr, roll, pitch;
    // centred yaw stick holds heading from gyro Z
    if (s2_q.yaw_mid) zl = -S_W'($signed(s2_q.gz_p));
    else              zl = S_W'($signed(s2_q.yaw_p));
    zf    = -zl;
    thr   = S_W'($signed(s2_q.thr_p));
    roll  = S_W'($signed(s2_q.roll_p));
    pitch = S_W'($signed(s2_q.pitch_p));
    s3_d.pax     = S_W'($signed(s2_q.ax_p)) + S_W'($signed(s2_q.axd_p));
    s3_d.pay     = S_W'($signed(s2_q.ay_p)) + S_W'($signed(s2_q.ayd_p));
    s3_d.pgx     = S_W'($signed(s2_q.gx_p)) + S_W'($signed(s2_q.gxd_p));
    s3_d.pgy     = S_W'($signed(s2_q.gy_p)) + S_W'($signed(s2_q.gyd_p));
    s3_d.left_c  = BASE_L_S + thr + roll + zl;
    s3_d.right_c = BASE_R_S + thr - roll + zl;
    s3_d.front_c = BASE_F_S + thr - pitch + zf;
    s3_d.back_c  = BASE_B_S + thr + pitch + zf;
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) s3_q <= s3_d;
  end

  // stage 4: apply PD terms and clamp
  always_comb begin
    left_d  = pwm_clamp($signed(s3_q.left_c) - $signed(s3_q.pax) - $signed(s3_q.pgx),
                        LO_S, HI_S);
    right_d = pwm_clamp($signed(s3_q.right_c) + $signed(s3_q.pax) + $signed(s3_q.pgx),
                        LO_S, HI_S);
    front_d = pwm_clamp($signed(s3_q.front_c) - $signed(s3_q.pay) + $signed(s3_q.pgy),
                        LO_S, HI_S);
    back_d  = pwm_clamp($signed(s3_q.back_c) + $signed(s3_q.pay) - $signed(s3_q.pgy),
                        LO_S, HI_S);
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      left_q  <= left_d;
      right_q <= right_d;
      front_q <= front_d;
      back_q  <= back_d;
    end
  end

  assign out_valid_o = v4_q;
  assign pwm_left_o  = left_q;
  assign pwm_right_o = right_q;
  assign pwm_front_o = front_q;
  assign pwm_back_o  = back_q;

`ifndef SYNTHESIS
  // results stay at or below the upper bound of the clamp window
  a_pwm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (PWM_LO > PWM_HI) ||
      ({20'd0, pwm_left_o}  <= PWM_HI && {20'd0, pwm_right_o} <= PWM_HI &&
       {20'd0, pwm_front_o} <= PWM_HI && {20'd0, pwm_back_o}  <= PWM_HI))
    else $error("pwm word outside clamp window");

  // an accepted word becomes the previous sample
  a_prev_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> prev_ax_q == $past(angle_x_i) &&
      prev_gy_q == $past(rate_y_i))
    else $error("previous sample not updated on accept");

  // without an accepted word the previous samples hold
  a_prev_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && in_ready_o) |=> $stable(prev_ax_q) && $stable(prev_ay_q) &&
      $stable(prev_gx_q) && $stable(prev_gy_q))
    else $error("previous sample changed without accept");

  // a finished PD word reaches the output stage when there is room
  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && (!v4_q || out_ready_i) |=> out_valid_o)
    else $error("word lost between sum and clamp stages");
`endif

endmodule
